// File: rtl/core/catmull_rom_curve_point_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the curve point evaluator.
// ---------------------------------------------------------------------------
`ifndef CATMULL_ROM_CURVE_POINT_ASSERT_SVH
`define CATMULL_ROM_CURVE_POINT_ASSERT_SVH
`ifndef SYNTH
`define CRC_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CRC_ASSERT_IMPL(label, clk, rst, prop, msg)
`define CRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/core/crc_pkg.sv
// ---------------------------------------------------------------------------
// crc_pkg: shared types and constants of the curve point evaluator.
// Holds payload structs, register indexes and command codes.
// ---------------------------------------------------------------------------
package crc_pkg;
   localparam int MAX_POINTS_DEF = 64;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_MODE = 1'b1;
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef struct packed {
      logic               command;
      logic [5:0]         point_index;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic [16:0]        param_t;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_type;
endpackage

// File: rtl/core/crc_ram.sv
// ---------------------------------------------------------------------------
// crc_ram: generic single write, single read RAM with registered read.
// ---------------------------------------------------------------------------
module crc_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/core/catmull_rom_curve_point.sv
// An evaluate transaction's result strobe comes through stage registers 1 to 5 and then the output register.
// Throughput: one transaction per cycle; four table copies give the four point reads.
// busy stays low; the receiver cannot stall, so the pipeline never holds.
// Reset clears valid bits and registers (point_count 4, clamp mode); the
// point table is undefined until loaded and needs no clearing pass.
// ---------------------------------------------------------------------------
// catmull_rom_curve_point: pipelined Catmull-Rom curve point evaluator.
// ---------------------------------------------------------------------------
`include "catmull_rom_curve_point_assert.svh"
module catmull_rom_curve_point #(
   parameter int MAX_POINTS = crc_pkg::MAX_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  crc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   output crc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [crc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = AW + 1;

   // Configuration registers.
   logic [6:0] point_count_ff;
   logic       loop_mode_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= 7'd4;
         loop_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            crc_pkg::CSR_POINT_COUNT: point_count_ff <= csr_wdata;
            crc_pkg::CSR_LOOP_MODE:   loop_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end
   assign busy = 1'b0;

   // Effective point count, saturated to [2, MAX_POINTS].
   logic [NW-1:0] n_eff;
   always_comb begin
      if (point_count_ff < 7'd2) n_eff = NW'(2);
      else if ({{(NW > 7 ? NW - 7 : 0){1'b0}}, point_count_ff} > MAX_POINTS)
         n_eff = NW'(MAX_POINTS);
      else n_eff = NW'(point_count_ff);
   end

   // Load writes into all four table copies.
   logic accept;
   logic do_load;
   assign accept = start && !busy;
   assign do_load = accept && req_data.command == crc_pkg::CMD_LOAD
      && {26'd0, req_data.point_index} < 32'(MAX_POINTS);

   // Stage 1: t*N.
   logic        s1_v_ff;
   logic [16:0] t_sat;
   logic [16+NW:0] tn_s1_ff, tn_in;
   logic [NW-1:0] n_s1_ff;
   logic        lp_s1_ff;
   assign t_sat = req_data.param_t > 17'd65536 ? 17'd65536 : req_data.param_t;
   assign tn_in = (17+NW)'(t_sat) * (17+NW)'(n_eff);
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else s1_v_ff <= accept && req_data.command == crc_pkg::CMD_EVAL;
      tn_s1_ff <= tn_in;
      n_s1_ff <= n_eff;
      lp_s1_ff <= loop_mode_ff;
   end

   // Stage 2: k, h and the four mapped indices.
   logic [NW:0] k_val;
   logic [16:0] h_val;
   logic [AW-1:0] idx_in [4];
   logic        s2_v_ff;
   logic [16:0] h_s2_ff;
   always_comb begin
      logic signed [NW+2:0] kn;
      logic signed [NW+2:0] nn;
      k_val = (NW+1)'((tn_s1_ff + (17+NW)'(65535)) >> 16);
      h_val = 17'(tn_s1_ff - (17+NW)'((NW+17)'(k_val) << 16) + (17+NW)'(65536));
      nn = (NW+3)'(n_s1_ff);
      for (int i = 0; i < 4; i++) begin
         kn = (NW+3)'(k_val) + (NW+3)'(i) - (NW+3)'(2);
         if (lp_s1_ff) begin
            if (kn < 0) kn = kn + nn;
            else if (kn >= nn) kn = kn - nn;
         end else begin
            if (kn < 0) kn = '0;
            else if (kn > nn - 1) kn = nn - 1;
         end
         idx_in[i] = AW'(kn);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else s2_v_ff <= s1_v_ff;
      h_s2_ff <= h_val;
   end

   // Table copies, one per basis tap; read data is registered (stage 2).
   logic [95:0] pt_rd [4];
   for (genvar g = 0; g < 4; g++) begin : g_tab
      crc_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_ram (
         .clock  (clock),
         .wr_en  (do_load),
         .wr_addr(AW'(req_data.point_index)),
         .wr_data({req_data.coord_x, req_data.coord_y, req_data.coord_z}),
         .rd_addr(idx_in[g]),
         .rd_data(pt_rd[g])
      );
   end

   // Stage 3: square of h; the point data moves along with it.
   logic        s3_v_ff;
   logic [33:0] h2_s3_ff;
   logic [16:0] h_s3_ff;
   logic [95:0] pt_s3_ff [4];
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else s3_v_ff <= s2_v_ff;
      h2_s3_ff <= 34'(h_s2_ff) * 34'(h_s2_ff);
      h_s3_ff <= h_s2_ff;
      for (int i = 0; i < 4; i++) begin
         pt_s3_ff[i] <= pt_rd[i];
      end
   end

   // Stage 4: h^3 and basis weights in Q2.30.
   logic        s4_v_ff;
   logic signed [31:0] w_s4_ff [4];
   logic [95:0] pt_s4_ff [4];
   always_ff @(posedge clock) begin
      logic signed [53:0] h3, h2s, h1s, p;
      logic signed [53:0] pv [4];
      h3 = 54'(h2_s3_ff) * 54'(h_s3_ff);
      h2s = 54'(h2_s3_ff) <<< 16;
      h1s = 54'(h_s3_ff) <<< 32;
      p = 54'(1) <<< 48;
      pv[0] = -h3 + (h2s <<< 1) - h1s;
      pv[1] = 3 * h3 - 5 * h2s + (p <<< 1);
      pv[2] = -3 * h3 + 4 * h2s + h1s;
      pv[3] = h3 - h2s;
      if (reset) s4_v_ff <= 1'b0;
      else s4_v_ff <= s3_v_ff;
      for (int i = 0; i < 4; i++) begin
         w_s4_ff[i] <= 32'((pv[i] + (54'(1) <<< 18)) >>> 19);
         pt_s4_ff[i] <= pt_s3_ff[i];
      end
   end

   // Stage 5: twelve products.
   logic        s5_v_ff;
   logic signed [63:0] prod_s5_ff [4][3];
   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else s5_v_ff <= s4_v_ff;
      for (int i = 0; i < 4; i++) begin
         for (int c = 0; c < 3; c++) begin
            prod_s5_ff[i][c] <= 64'(w_s4_ff[i]) *
               64'($signed(pt_s4_ff[i][95 - 32*c -: 32]));
         end
      end
   end

   // Stage 6: sum, round and saturate.
   logic rsp_valid_ff;
   crc_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      logic signed [65:0] acc;
      logic signed [35:0] r;
      logic signed [31:0] o [3];
      for (int c = 0; c < 3; c++) begin
         acc = 66'(prod_s5_ff[0][c]) + 66'(prod_s5_ff[1][c])
             + 66'(prod_s5_ff[2][c]) + 66'(prod_s5_ff[3][c]) + (66'(1) <<< 29);
         r = 36'(acc >>> 30);
         if (r > 36'sd2147483647) o[c] = 32'h7fffffff;
         else if (r < -36'sd2147483648) o[c] = 32'h80000000;
         else o[c] = 32'(r);
      end
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= s5_v_ff;
      rsp_ff <= '{out_x: o[0], out_y: o[1], out_z: o[2]};
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // Checks.
   `CRC_ASSERT_NEXT(a_busy_low, clock, reset, 1'b1, !busy, "busy asserted")
   `CRC_ASSERT_NEXT(a_pipe, clock, reset, s5_v_ff, rsp_valid, "lost result")
   `CRC_ASSERT_IMPL(a_nmin, clock, reset, n_eff >= NW'(2), "point count below two")
endmodule
